FILE: design/assert_macros.svh
// Concurrent assertion shorthands used by the design checker (acep_checker).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the clock after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// Consequent must hold in the same clock as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

FILE: design/acep_pkg.sv
`default_nettype none
package acep_pkg;

   localparam int GLYPH_WIDTH         = 8;
   localparam int GLYPH_HEIGHT        = 16;
   localparam int COORD_W             = 13;
   localparam int NUM_W               = 16;
   localparam int ATTR_W              = 18;
   localparam int SHAPE_W             = 5;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;
   localparam int DEFAULT_QUEUE_DEPTH = 4;

   localparam logic [COORD_W-1:0] WIDTH_RESET      = 13'd640;
   localparam logic [COORD_W-1:0] HEIGHT_RESET     = 13'd480;
   localparam logic [ATTR_W-1:0]  ATTR_RESET       = 18'h0000a;
   localparam logic [SHAPE_W-1:0] SHAPE_HIGH_RESET = 5'd3;

   localparam logic [7:0] BYTE_ESC      = 8'h1b;
   localparam logic [7:0] BYTE_LBRACKET = 8'h5b;
   localparam logic [7:0] BYTE_SEMI     = 8'h3b;
   localparam logic [7:0] BYTE_NL       = 8'h0a;
   localparam logic [7:0] BYTE_ZERO     = 8'h30;
   localparam logic [7:0] BYTE_NINE     = 8'h39;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      MODE_TEXT,
      MODE_ESC,
      MODE_SEQ
   } mode_type;

   typedef enum logic [2:0] {
      TK_CURSOR,
      TK_TEXT,
      TK_ESC_TEXT,
      TK_FINAL,
      TK_NL_SCROLL,
      TK_CLEAR
   } token_kind_type;

   typedef enum logic [1:0] {
      OP_GLYPH,
      OP_BLANK,
      OP_SCROLL,
      OP_CURSOR
   } op_type;

   typedef struct packed {
      token_kind_type   kind;
      logic [7:0]       code;
      logic [NUM_W-1:0] arg_a;
      logic [NUM_W-1:0] arg_b;
   } token_type;

   typedef struct packed {
      logic      push;
      token_type token;
   } queue_wr_type;

   typedef struct packed {
      logic      valid;
      token_type token;
   } queue_rd_type;

   typedef struct packed {
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
   } screen_cfg_type;

endpackage
`default_nettype wire

FILE: design/acep_front.sv
`default_nettype none
module acep_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire                  req_cmd,
   input  wire  [7:0]           req_byte_in,
   input  wire                  queue_full,
   output acep_pkg::queue_wr_type wr
);
   import acep_pkg::*;

   mode_type         mode_ff, mode_in;
   logic [NUM_W-1:0] num_now_ff, num_now_in;
   logic [NUM_W-1:0] num_before_ff, num_before_in;
   logic             accept;
   logic [19:0]      num_scaled;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      mode_in        = mode_ff;
      num_now_in     = num_now_ff;
      num_before_in  = num_before_ff;
      wr.push        = 1'b0;
      wr.token.kind  = TK_TEXT;
      wr.token.code  = req_byte_in;
      wr.token.arg_a = num_before_ff;
      wr.token.arg_b = num_now_ff;
      num_scaled     = {1'b0, num_now_ff, 3'b000} + {3'b000, num_now_ff, 1'b0}
                       + {16'd0, req_byte_in[3:0]};
      if (accept) begin
         if (req_cmd) begin
            wr.push       = 1'b1;
            wr.token.kind = TK_CURSOR;
         end else begin
            case (mode_ff)
               MODE_SEQ: begin
                  if (req_byte_in inside {[BYTE_ZERO:BYTE_NINE]}) begin
                     num_now_in = (num_scaled > 20'h0ffff) ? 16'hffff : num_scaled[15:0];
                  end else if (req_byte_in == BYTE_SEMI) begin
                     num_before_in = num_now_ff;
                     num_now_in    = '0;
                  end else begin
                     mode_in       = MODE_TEXT;
                     wr.push       = 1'b1;
                     wr.token.kind = TK_FINAL;
                  end
               end
               MODE_ESC: begin
                  if (req_byte_in == BYTE_LBRACKET) begin
                     mode_in       = MODE_SEQ;
                     num_now_in    = '0;
                     num_before_in = '0;
                  end else if (req_byte_in == BYTE_ESC) begin
                     wr.push = 1'b1;
                  end else begin
                     mode_in       = MODE_TEXT;
                     wr.push       = 1'b1;
                     wr.token.kind = TK_ESC_TEXT;
                  end
               end
               default: begin
                  if (req_byte_in == BYTE_ESC) begin
                     mode_in = MODE_ESC;
                  end else begin
                     mode_in = MODE_TEXT;
                     wr.push = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_TEXT;
         num_now_ff    <= '0;
         num_before_ff <= '0;
      end else begin
         mode_ff       <= mode_in;
         num_now_ff    <= num_now_in;
         num_before_ff <= num_before_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/acep_queue.sv
`default_nettype none
module acep_queue #(
   parameter int DEPTH = acep_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire                    clock,
   input  wire                    reset,
   input  acep_pkg::queue_wr_type wr,
   input  wire                    pop,
   output logic                   full,
   output acep_pkg::queue_rd_type rd
);
   import acep_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   token_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd.valid = (count_ff != '0);
   assign rd.token = entries_ff[rd_ptr_ff];
   assign do_push  = wr.push && !full;
   assign do_pop   = pop && rd.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wr.token;
      end
   end

endmodule
`default_nettype wire

FILE: design/acep_back.sv
`default_nettype none
module acep_back (
   input  wire                      clock,
   input  wire                      reset,
   input  acep_pkg::queue_rd_type   rd,
   output logic                     pop,
   input  acep_pkg::screen_cfg_type cfg,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic [1:0]               rsp_op,
   output logic [12:0]              rsp_pos_x,
   output logic [12:0]              rsp_pos_y,
   output logic [7:0]               rsp_glyph,
   output logic [7:0]               rsp_fg_color,
   output logic [7:0]               rsp_bg_color,
   output logic                     rsp_underline,
   output logic [12:0]              rsp_span,
   output logic [4:0]               rsp_cursor_first,
   output logic [4:0]               rsp_cursor_stop,
   output logic                     rsp_last
);
   import acep_pkg::*;

   localparam logic [7:0] FIN_SGR     = 8'h6d;
   localparam logic [7:0] FIN_UP      = 8'h41;
   localparam logic [7:0] FIN_DOWN    = 8'h42;
   localparam logic [7:0] FIN_RIGHT   = 8'h43;
   localparam logic [7:0] FIN_LEFT    = 8'h44;
   localparam logic [7:0] FIN_HOME    = 8'h48;
   localparam logic [7:0] FIN_CLEAR   = 8'h4a;
   localparam logic [7:0] FIN_ERASE   = 8'h4b;
   localparam logic [7:0] FIN_SAVE    = 8'h73;
   localparam logic [7:0] FIN_RESTORE = 8'h75;
   localparam logic [7:0] FIN_HIDE    = 8'h6c;
   localparam logic [7:0] FIN_SHAPE   = 8'h68;

   localparam logic [NUM_W-1:0] SGR_RESET     = 16'd0;
   localparam logic [NUM_W-1:0] SGR_BOLD      = 16'd1;
   localparam logic [NUM_W-1:0] SGR_DIM       = 16'd2;
   localparam logic [NUM_W-1:0] SGR_UNDERLINE = 16'd4;
   localparam logic [NUM_W-1:0] SGR_BLINK     = 16'd5;
   localparam logic [NUM_W-1:0] SGR_INVERSE   = 16'd7;
   localparam logic [NUM_W-1:0] SGR_HIDDEN    = 16'd8;
   localparam logic [NUM_W-1:0] SGR_FG_FIRST  = 16'd30;
   localparam logic [NUM_W-1:0] SGR_FG_LAST   = 16'd37;
   localparam logic [NUM_W-1:0] SGR_BG_FIRST  = 16'd40;
   localparam logic [NUM_W-1:0] SGR_BG_LAST   = 16'd47;

   localparam logic [COORD_W-1:0] COORD_MAX = '1;
   localparam logic [SHAPE_W-1:0] SHAPE_MAX = SHAPE_W'(GLYPH_HEIGHT);
   localparam int PROD_W = NUM_W + COORD_W;

   function automatic logic [ATTR_W-1:0] apply_sgr(input logic [ATTR_W-1:0] attr,
                                                   input logic [NUM_W-1:0]  v);
      logic [ATTR_W-1:0] r;
      logic [7:0]        sub;
      r   = attr;
      sub = '0;
      case (v)
         SGR_RESET:     r = 18'h00007;
         SGR_BOLD:      r = attr | 18'h00008;
         SGR_DIM:       r = attr | 18'h00800;
         SGR_UNDERLINE: r = attr | 18'h10000;
         SGR_BLINK:     r = attr | 18'h20000;
         SGR_INVERSE:   r = attr ^ 18'h0ffff;
         SGR_HIDDEN:    r = attr & 18'h0ffff;
         default: begin
            if (v inside {[SGR_FG_FIRST:SGR_FG_LAST]}) begin
               sub      = v[7:0] - SGR_FG_FIRST[7:0];
               r[7:0]   = sub;
            end else if (v inside {[SGR_BG_FIRST:SGR_BG_LAST]}) begin
               sub      = v[7:0] - SGR_BG_FIRST[7:0];
               r[15:8]  = sub;
            end
         end
      endcase
      return r;
   endfunction

   logic               cur_valid_ff, cur_valid_in;
   token_type          cur_ff, cur_in;
   logic [COORD_W-1:0] cursor_x_ff, cursor_x_in;
   logic [COORD_W-1:0] cursor_y_ff, cursor_y_in;
   logic [COORD_W-1:0] saved_x_ff, saved_x_in;
   logic [COORD_W-1:0] saved_y_ff, saved_y_in;
   logic [SHAPE_W-1:0] shape_low_ff, shape_low_in;
   logic [SHAPE_W-1:0] shape_high_ff, shape_high_in;
   logic [ATTR_W-1:0]  attr_ff, attr_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   logic               rsp_valid_ff, rsp_valid_in;
   op_type             rsp_op_ff;
   logic [COORD_W-1:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_span_ff;
   logic [7:0]         rsp_glyph_ff;
   logic [ATTR_W-1:0]  rsp_attr_ff;
   logic [SHAPE_W-1:0] rsp_cursor_first_ff, rsp_cursor_stop_ff;
   logic               rsp_last_ff;

   logic               out_free, step, emit, done;
   token_kind_type     next_kind;
   op_type             e_op;
   logic [COORD_W-1:0] e_x, e_y, e_span;
   logic [7:0]         e_glyph;
   logic [SHAPE_W-1:0] e_cf, e_cs;
   logic               e_last;

   logic [COORD_W-1:0] x_max, y_max;
   logic [COORD_W:0]   x_sum, y_sum;
   logic [COORD_W-1:0] x_adv, y_adv, y_diff;
   logic [19:0]        move_v;
   logic [20:0]        move_sum;
   logic [NUM_W-1:0]   shape_arg;
   logic [ATTR_W-1:0]  attr_a;

   always_comb begin
      x_max    = (cfg.width >= COORD_W'(GLYPH_WIDTH))
                 ? cfg.width - COORD_W'(GLYPH_WIDTH) : '0;
      y_max    = (cfg.height >= COORD_W'(GLYPH_HEIGHT))
                 ? cfg.height - COORD_W'(GLYPH_HEIGHT) : '0;
      x_sum    = {1'b0, cursor_x_ff} + (COORD_W+1)'(GLYPH_WIDTH);
      y_sum    = {1'b0, cursor_y_ff} + (COORD_W+1)'(GLYPH_HEIGHT);
      x_adv    = x_sum[COORD_W] ? COORD_MAX : x_sum[COORD_W-1:0];
      y_adv    = y_sum[COORD_W] ? COORD_MAX : y_sum[COORD_W-1:0];
      y_diff   = cursor_y_ff - y_max;
      move_v   = '0;
      move_sum = '0;
      shape_arg = '0;
      attr_a   = attr_ff;

      out_free = !rsp_valid_ff || rsp_ready;
      step     = cur_valid_ff && out_free;

      emit      = 1'b0;
      done      = 1'b1;
      next_kind = cur_ff.kind;
      e_op      = OP_GLYPH;
      e_x       = cursor_x_ff;
      e_y       = cursor_y_ff;
      e_span    = '0;
      e_glyph   = '0;
      e_cf      = '0;
      e_cs      = '0;
      e_last    = 1'b1;

      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      saved_x_in    = saved_x_ff;
      saved_y_in    = saved_y_ff;
      shape_low_in  = shape_low_ff;
      shape_high_in = shape_high_ff;
      attr_in       = attr_ff;
      prod_in       = prod_ff;

      case (cur_ff.kind)
         TK_CURSOR: begin
            emit = 1'b1;
            e_op = OP_CURSOR;
            e_cf = SHAPE_MAX - shape_high_ff;
            e_cs = SHAPE_MAX - shape_low_ff;
         end
         TK_ESC_TEXT: begin
            emit        = 1'b1;
            e_glyph     = BYTE_ESC;
            e_last      = 1'b0;
            done        = 1'b0;
            next_kind   = TK_TEXT;
            cursor_x_in = x_adv;
         end
         TK_TEXT: begin
            emit = 1'b1;
            if (cur_ff.code == BYTE_NL) begin
               e_op        = OP_BLANK;
               e_span      = COORD_W'(GLYPH_WIDTH);
               cursor_x_in = '0;
               cursor_y_in = y_adv;
               if (y_adv > y_max) begin
                  e_last    = 1'b0;
                  done      = 1'b0;
                  next_kind = TK_NL_SCROLL;
               end
            end else begin
               e_glyph     = cur_ff.code;
               cursor_x_in = x_adv;
            end
         end
         TK_NL_SCROLL: begin
            emit        = 1'b1;
            e_op        = OP_SCROLL;
            e_x         = '0;
            e_y         = '0;
            e_span      = (y_diff > cfg.height) ? cfg.height : y_diff;
            cursor_y_in = y_max;
         end
         TK_CLEAR: begin
            emit   = 1'b1;
            e_op   = OP_SCROLL;
            e_x    = '0;
            e_y    = '0;
            e_span = (prod_ff > PROD_W'(cfg.height)) ? cfg.height : prod_ff[COORD_W-1:0];
         end
         TK_FINAL: begin
            case (cur_ff.code)
               FIN_SGR: begin
                  if (cur_ff.arg_a != '0) begin
                     attr_a = apply_sgr(attr_ff, cur_ff.arg_a);
                  end
                  attr_in = apply_sgr(attr_a, cur_ff.arg_b);
               end
               FIN_UP: begin
                  move_v      = {cur_ff.arg_b, 4'b0000};
                  cursor_y_in = ({7'd0, cursor_y_ff} > move_v)
                                ? cursor_y_ff - move_v[COORD_W-1:0] : '0;
               end
               FIN_DOWN: begin
                  move_sum    = {8'd0, cursor_y_ff} + {1'b0, cur_ff.arg_b, 4'b0000};
                  cursor_y_in = (move_sum > {8'd0, y_max}) ? y_max : move_sum[COORD_W-1:0];
               end
               FIN_RIGHT: begin
                  move_sum    = {8'd0, cursor_x_ff} + {2'b00, cur_ff.arg_b, 3'b000};
                  cursor_x_in = (move_sum > {8'd0, x_max}) ? x_max : move_sum[COORD_W-1:0];
               end
               FIN_LEFT: begin
                  move_v      = {1'b0, cur_ff.arg_b, 3'b000};
                  cursor_x_in = ({7'd0, cursor_x_ff} > move_v)
                                ? cursor_x_ff - move_v[COORD_W-1:0] : '0;
               end
               FIN_HOME: begin
                  cursor_x_in = (cur_ff.arg_b > NUM_W'(COORD_MAX))
                                ? COORD_MAX : cur_ff.arg_b[COORD_W-1:0];
                  cursor_y_in = (cur_ff.arg_a > NUM_W'(COORD_MAX))
                                ? COORD_MAX : cur_ff.arg_a[COORD_W-1:0];
               end
               FIN_CLEAR: begin
                  done      = 1'b0;
                  next_kind = TK_CLEAR;
                  prod_in   = PROD_W'(cur_ff.arg_b) * PROD_W'(y_max);
               end
               FIN_ERASE: begin
                  emit   = 1'b1;
                  e_op   = OP_BLANK;
                  e_span = (cfg.width > cursor_x_ff) ? cfg.width - cursor_x_ff : '0;
               end
               FIN_SAVE: begin
                  saved_x_in = cursor_x_ff;
                  saved_y_in = cursor_y_ff;
               end
               FIN_RESTORE: begin
                  cursor_x_in = saved_x_ff;
                  cursor_y_in = saved_y_ff;
               end
               FIN_HIDE: begin
                  shape_low_in  = '0;
                  shape_high_in = '0;
               end
               FIN_SHAPE: begin
                  shape_low_in  = (cur_ff.arg_a > NUM_W'(GLYPH_HEIGHT))
                                  ? SHAPE_MAX : cur_ff.arg_a[SHAPE_W-1:0];
                  shape_arg     = (cur_ff.arg_b != '0) ? cur_ff.arg_b : NUM_W'(SHAPE_HIGH_RESET);
                  shape_high_in = (shape_arg > NUM_W'(GLYPH_HEIGHT))
                                  ? SHAPE_MAX : shape_arg[SHAPE_W-1:0];
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      pop = rd.valid && (!cur_valid_ff || (step && done));

      cur_in = cur_ff;
      if (pop) begin
         cur_in = rd.token;
      end else if (step && !done) begin
         cur_in.kind = next_kind;
      end
      cur_valid_in = pop ? 1'b1 : ((step && done) ? 1'b0 : cur_valid_ff);

      if (step && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         saved_x_ff    <= '0;
         saved_y_ff    <= '0;
         shape_low_ff  <= '0;
         shape_high_ff <= SHAPE_HIGH_RESET;
         attr_ff       <= ATTR_RESET;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            cursor_x_ff   <= cursor_x_in;
            cursor_y_ff   <= cursor_y_in;
            saved_x_ff    <= saved_x_in;
            saved_y_ff    <= saved_y_in;
            shape_low_ff  <= shape_low_in;
            shape_high_ff <= shape_high_in;
            attr_ff       <= attr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (step) begin
         prod_ff <= prod_in;
      end
      if (step && emit) begin
         rsp_op_ff           <= e_op;
         rsp_pos_x_ff        <= e_x;
         rsp_pos_y_ff        <= e_y;
         rsp_glyph_ff        <= e_glyph;
         rsp_attr_ff         <= attr_ff;
         rsp_span_ff         <= e_span;
         rsp_cursor_first_ff <= e_cf;
         rsp_cursor_stop_ff  <= e_cs;
         rsp_last_ff         <= e_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_op           = rsp_op_ff;
   assign rsp_pos_x        = rsp_pos_x_ff;
   assign rsp_pos_y        = rsp_pos_y_ff;
   assign rsp_glyph        = rsp_glyph_ff;
   assign rsp_fg_color     = rsp_attr_ff[7:0];
   assign rsp_bg_color     = rsp_attr_ff[15:8];
   assign rsp_underline    = rsp_attr_ff[16];
   assign rsp_span         = rsp_span_ff;
   assign rsp_cursor_first = rsp_cursor_first_ff;
   assign rsp_cursor_stop  = rsp_cursor_stop_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
`default_nettype wire

FILE: design/ansi_console_escape_parser.sv
`default_nettype none
// Console escape parser: takes one console byte (or a show-cursor command) per beat and
// returns the drawing beats it causes, the final one marked by rsp_last. The front end
// tracks ESC [ n ; m parsing and takes one beat every cycle while its token queue
// (QUEUE_DEPTH entries) has room; the back end owns cursor, attributes and shape and
// sends one result beat per cycle, while rsp_ready allows, through a single output
// register. Plain text, cursor commands and silent sequence bytes thus run at one beat
// per cycle. A scrolling newline gives a blank beat then a scroll beat; ESC and a plain
// byte give the ESC glyph then the byte; a clear (J) does the line-count multiply, then
// a scroll beat. Bytes that draw nothing reach the back end only as control-sequence
// finals. Screen width and height sit at byte addresses 0 and 4 of the register port.
module ansi_console_escape_parser #(
   parameter int QUEUE_DEPTH = acep_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_cmd,
   input  wire  [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_op,
   output logic [12:0] rsp_pos_x,
   output logic [12:0] rsp_pos_y,
   output logic [7:0]  rsp_glyph,
   output logic [7:0]  rsp_fg_color,
   output logic [7:0]  rsp_bg_color,
   output logic        rsp_underline,
   output logic [12:0] rsp_span,
   output logic [4:0]  rsp_cursor_first,
   output logic [4:0]  rsp_cursor_stop,
   output logic        rsp_last,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [acep_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire  [acep_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [acep_pkg::CSR_DATA_W-1:0] prdata,
   output logic        pready
);
   import acep_pkg::*;

   logic [COORD_W-1:0] width_ff, height_ff;
   logic               csr_write;
   logic               csr_index;
   logic [COORD_W-1:0] csr_read;
   screen_cfg_type     cfg;
   queue_wr_type       wr;
   queue_rd_type       rd;
   logic               queue_full;
   logic               pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2];
   assign csr_read  = (csr_index == CSR_SCREEN_HEIGHT) ? height_ff : width_ff;
   assign prdata    = {{(CSR_DATA_W-COORD_W){1'b0}}, csr_read};
   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= pwdata[COORD_W-1:0];
            CSR_SCREEN_HEIGHT: height_ff <= pwdata[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   acep_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_byte_in (req_byte_in),
      .queue_full  (queue_full),
      .wr          (wr)
   );

   acep_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .pop   (pop),
      .full  (queue_full),
      .rd    (rd)
   );

   acep_back u_back (
      .clock            (clock),
      .reset            (reset),
      .rd               (rd),
      .pop              (pop),
      .cfg              (cfg),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_op           (rsp_op),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_glyph        (rsp_glyph),
      .rsp_fg_color     (rsp_fg_color),
      .rsp_bg_color     (rsp_bg_color),
      .rsp_underline    (rsp_underline),
      .rsp_span         (rsp_span),
      .rsp_cursor_first (rsp_cursor_first),
      .rsp_cursor_stop  (rsp_cursor_stop),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

FILE: design/acep_checker.sv
`default_nettype none
`include "assert_macros.svh"
module acep_checker (
   input wire         clock,
   input wire         reset,
   input wire         rsp_valid,
   input wire         rsp_ready,
   input wire  [1:0]  rsp_op,
   input wire  [12:0] rsp_pos_x,
   input wire  [12:0] rsp_pos_y,
   input wire  [7:0]  rsp_glyph,
   input wire  [12:0] rsp_span,
   input wire  [4:0]  rsp_cursor_first,
   input wire  [4:0]  rsp_cursor_stop,
   input wire         rsp_last,
   input wire  [31:0] prdata
);
   import acep_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_op) && $stable(rsp_pos_x) && $stable(rsp_last), "result beat changed while stalled")
   `ASSERT_IMPLY(a_scroll_origin, clock, reset, rsp_valid && rsp_op == OP_SCROLL, rsp_pos_x == '0 && rsp_pos_y == '0, "scroll beat not at origin")
   `ASSERT_IMPLY(a_glyph_only, clock, reset, rsp_valid && rsp_op != OP_GLYPH, rsp_glyph == '0, "glyph code on a non-glyph beat")
   `ASSERT_IMPLY(a_cursor_rows, clock, reset, rsp_valid && rsp_op == OP_CURSOR, rsp_cursor_first <= 5'd16 && rsp_cursor_stop <= 5'd16 && rsp_span == '0, "cursor rows out of glyph")
   `ASSERT_AT(a_prdata_range, clock, reset, prdata[31:13] == '0, "register read wider than 13 bits")

endmodule

bind ansi_console_escape_parser acep_checker u_acep_checker (.*);
`default_nettype wire

FILE: bench/acep_checker.sv
`timescale 1ns / 1ps
package acep_tb_pkg;

   localparam logic [7:0] FIN_SGR       = "m";
   localparam logic [7:0] FIN_UP        = "A";
   localparam logic [7:0] FIN_DOWN      = "B";
   localparam logic [7:0] FIN_RIGHT     = "C";
   localparam logic [7:0] FIN_LEFT      = "D";
   localparam logic [7:0] FIN_HOME      = "H";
   localparam logic [7:0] FIN_CLEAR     = "J";
   localparam logic [7:0] FIN_ERASE     = "K";
   localparam logic [7:0] FIN_SAVE      = "s";
   localparam logic [7:0] FIN_RESTORE   = "u";
   localparam logic [7:0] FIN_SHAPE_OFF = "l";
   localparam logic [7:0] FIN_SHAPE_SET = "h";

   localparam int unsigned SGR_RESET     = 0;
   localparam int unsigned SGR_BOLD      = 1;
   localparam int unsigned SGR_DIM       = 2;
   localparam int unsigned SGR_UNDERLINE = 4;
   localparam int unsigned SGR_BLINK     = 5;
   localparam int unsigned SGR_INVERT    = 7;
   localparam int unsigned SGR_HIDE      = 8;
   localparam int unsigned SGR_FG_FIRST  = 30;
   localparam int unsigned SGR_FG_LAST   = 37;
   localparam int unsigned SGR_BG_FIRST  = 40;
   localparam int unsigned SGR_BG_LAST   = 47;

endpackage

module acep_scoreboard
   import acep_pkg::*;
   import acep_tb_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_ready,
   input  wire         req_cmd,
   input  wire  [7:0]  req_byte_in,
   input  wire         rsp_valid,
   input  wire         rsp_ready,
   input  wire  [1:0]  rsp_op,
   input  wire  [12:0] rsp_pos_x,
   input  wire  [12:0] rsp_pos_y,
   input  wire  [7:0]  rsp_glyph,
   input  wire  [7:0]  rsp_fg_color,
   input  wire  [7:0]  rsp_bg_color,
   input  wire         rsp_underline,
   input  wire  [12:0] rsp_span,
   input  wire  [4:0]  rsp_cursor_first,
   input  wire  [4:0]  rsp_cursor_stop,
   input  wire         rsp_last,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [CSR_ADDR_W-1:0] paddr,
   input  wire  [CSR_DATA_W-1:0] pwdata,
   input  wire         pready,
   output int          fail_count,
   output int          pending
);

   localparam int unsigned COORD_MAX = 8191;
   localparam logic [NUM_W-1:0]  NUM_MAX       = 16'hffff;
   localparam logic [ATTR_W-1:0] ATTR_SGR_BASE = 18'h00007;
   localparam logic [ATTR_W-1:0] ATTR_BOLD     = 18'h00008;
   localparam logic [ATTR_W-1:0] ATTR_DIM      = 18'h00800;
   localparam logic [ATTR_W-1:0] ATTR_UL       = 18'h10000;
   localparam logic [ATTR_W-1:0] ATTR_BLINK    = 18'h20000;

   typedef struct {
      op_type      op;
      logic [12:0] pos_x;
      logic [12:0] pos_y;
      logic [7:0]  glyph;
      logic [7:0]  fg_color;
      logic [7:0]  bg_color;
      logic        underline;
      logic [12:0] span;
      logic [4:0]  cursor_first;
      logic [4:0]  cursor_stop;
      logic        last;
   } draw_beat_type;

   draw_beat_type draw_q[$];
   draw_beat_type held;
   draw_beat_type want;
   bit            have_held;

   logic [COORD_W-1:0] scr_w, scr_h;
   mode_type           mode;
   logic [NUM_W-1:0]   num_now, num_prev;
   logic [COORD_W-1:0] cur_x, cur_y, save_x, save_y;
   logic [SHAPE_W-1:0] shp_low, shp_high;
   logic [ATTR_W-1:0]  attr;

   function automatic int unsigned sat13(input int unsigned v);
      return v > COORD_MAX ? COORD_MAX : v;
   endfunction

   function automatic int unsigned lim_x();
      return scr_w >= GLYPH_WIDTH ? scr_w - GLYPH_WIDTH : 0;
   endfunction

   function automatic int unsigned lim_y();
      return scr_h >= GLYPH_HEIGHT ? scr_h - GLYPH_HEIGHT : 0;
   endfunction

   function automatic void push_draw(input op_type op, input int unsigned px,
                                     input int unsigned py, input int unsigned g,
                                     input int unsigned span, input int unsigned cf,
                                     input int unsigned cs);
      draw_beat_type d;
      d.op           = op;
      d.pos_x        = 13'(px);
      d.pos_y        = 13'(py);
      d.glyph        = 8'(g);
      d.fg_color     = attr[7:0];
      d.bg_color     = attr[15:8];
      d.underline    = attr[16];
      d.span         = 13'(span);
      d.cursor_first = 5'(cf);
      d.cursor_stop  = 5'(cs);
      d.last         = 1'b0;
      if (have_held)
         draw_q.push_back(held);
      held      = d;
      have_held = 1'b1;
   endfunction

   function automatic void put_text(input logic [7:0] b);
      int unsigned ym;
      int unsigned lines;
      if (b == BYTE_NL) begin
         ym = lim_y();
         push_draw(OP_BLANK, cur_x, cur_y, 0, GLYPH_WIDTH, 0, 0);
         cur_x = '0;
         cur_y = 13'(sat13(cur_y + GLYPH_HEIGHT));
         if (cur_y > ym) begin
            lines = cur_y - ym;
            if (lines > scr_h)
               lines = scr_h;
            push_draw(OP_SCROLL, 0, 0, 0, lines, 0, 0);
            cur_y = 13'(ym);
         end
      end else begin
         push_draw(OP_GLYPH, cur_x, cur_y, b, 0, 0, 0);
         cur_x = 13'(sat13(cur_x + GLYPH_WIDTH));
      end
   endfunction

   function automatic void set_attr(input int unsigned v);
      case (v)
         SGR_RESET:     attr = ATTR_SGR_BASE;
         SGR_BOLD:      attr = attr | ATTR_BOLD;
         SGR_DIM:       attr = attr | ATTR_DIM;
         SGR_UNDERLINE: attr = attr | ATTR_UL;
         SGR_BLINK:     attr = attr | ATTR_BLINK;
         SGR_INVERT:    attr[15:0] = ~attr[15:0];
         SGR_HIDE:      attr[17:16] = 2'b00;
         default: begin
            if (v >= SGR_FG_FIRST && v <= SGR_FG_LAST)
               attr[7:0] = 8'(v - SGR_FG_FIRST);
            else if (v >= SGR_BG_FIRST && v <= SGR_BG_LAST)
               attr[15:8] = 8'(v - SGR_BG_FIRST);
         end
      endcase
   endfunction

   function automatic void finish_sequence(input logic [7:0] b);
      int unsigned      a, v, xm, ym, t;
      longint unsigned  lines;
      a  = num_prev;
      v  = num_now;
      xm = lim_x();
      ym = lim_y();
      case (b)
         FIN_SGR: begin
            if (a != 0)
               set_attr(a);
            set_attr(v);
         end
         FIN_UP: begin
            t = v * GLYPH_HEIGHT;
            cur_y = cur_y > t ? 13'(cur_y - t) : 13'd0;
         end
         FIN_DOWN: begin
            t = cur_y + v * GLYPH_HEIGHT;
            cur_y = t > ym ? 13'(ym) : 13'(t);
         end
         FIN_RIGHT: begin
            t = cur_x + v * GLYPH_WIDTH;
            cur_x = t > xm ? 13'(xm) : 13'(t);
         end
         FIN_LEFT: begin
            t = v * GLYPH_WIDTH;
            cur_x = cur_x > t ? 13'(cur_x - t) : 13'd0;
         end
         FIN_CLEAR: begin
            lines = 64'(v) * 64'(ym);
            if (lines > scr_h)
               lines = scr_h;
            push_draw(OP_SCROLL, 0, 0, 0, 32'(lines), 0, 0);
         end
         FIN_ERASE: begin
            t = scr_w > cur_x ? scr_w - cur_x : 0;
            push_draw(OP_BLANK, cur_x, cur_y, 0, t, 0, 0);
         end
         FIN_HOME: begin
            cur_x = 13'(sat13(v));
            cur_y = 13'(sat13(a));
         end
         FIN_SAVE: begin
            save_x = cur_x;
            save_y = cur_y;
         end
         FIN_RESTORE: begin
            cur_x = save_x;
            cur_y = save_y;
         end
         FIN_SHAPE_OFF: begin
            shp_low  = '0;
            shp_high = '0;
         end
         FIN_SHAPE_SET: begin
            shp_low = a > GLYPH_HEIGHT ? 5'(GLYPH_HEIGHT) : 5'(a);
            t = v != 0 ? v : SHAPE_HIGH_RESET;
            shp_high = t > GLYPH_HEIGHT ? 5'(GLYPH_HEIGHT) : 5'(t);
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_draws(input logic cmd, input logic [7:0] b);
      int unsigned grown;
      if (cmd) begin
         push_draw(OP_CURSOR, cur_x, cur_y, 0, 0, GLYPH_HEIGHT - shp_high,
                   GLYPH_HEIGHT - shp_low);
      end else if (mode == MODE_SEQ) begin
         if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
            grown = num_now * 10 + (b - BYTE_ZERO);
            num_now = grown > NUM_MAX ? NUM_MAX : 16'(grown);
         end else if (b == BYTE_SEMI) begin
            num_prev = num_now;
            num_now  = '0;
         end else begin
            mode = MODE_TEXT;
            finish_sequence(b);
         end
      end else if (mode == MODE_ESC) begin
         if (b == BYTE_LBRACKET) begin
            mode     = MODE_SEQ;
            num_now  = '0;
            num_prev = '0;
         end else begin
            put_text(BYTE_ESC);
            if (b == BYTE_ESC) begin
               mode = MODE_ESC;
            end else begin
               mode = MODE_TEXT;
               put_text(b);
            end
         end
      end else if (b == BYTE_ESC) begin
         mode = MODE_ESC;
      end else begin
         put_text(b);
      end
      if (have_held) begin
         held.last = 1'b1;
         draw_q.push_back(held);
         have_held = 1'b0;
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned exp_val,
                                       input int unsigned got_val);
      if (exp_val != got_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         scr_w      = WIDTH_RESET;
         scr_h      = HEIGHT_RESET;
         mode       = MODE_TEXT;
         num_now    = '0;
         num_prev   = '0;
         cur_x      = '0;
         cur_y      = '0;
         save_x     = '0;
         save_y     = '0;
         shp_low    = '0;
         shp_high   = SHAPE_HIGH_RESET;
         attr       = ATTR_RESET;
         have_held  = 1'b0;
         fail_count = 0;
         draw_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (draw_q.size() == 0) begin
               $error("draw beat with nothing expected: op %0d x %0d y %0d",
                      rsp_op, rsp_pos_x, rsp_pos_y);
               fail_count++;
            end else begin
               want = draw_q.pop_front();
               check_field("op", want.op, rsp_op);
               check_field("pos_x", want.pos_x, rsp_pos_x);
               check_field("pos_y", want.pos_y, rsp_pos_y);
               check_field("glyph", want.glyph, rsp_glyph);
               check_field("fg_color", want.fg_color, rsp_fg_color);
               check_field("bg_color", want.bg_color, rsp_bg_color);
               check_field("underline", want.underline, rsp_underline);
               check_field("span", want.span, rsp_span);
               check_field("cursor_first", want.cursor_first, rsp_cursor_first);
               check_field("cursor_stop", want.cursor_stop, rsp_cursor_stop);
               check_field("last", want.last, rsp_last);
            end
         end
         if (req_valid && req_ready)
            predict_draws(req_cmd, req_byte_in);
         if (psel && penable && pwrite && pready) begin
            if (paddr[CSR_ADDR_W-1] == CSR_SCREEN_HEIGHT)
               scr_h = pwdata[COORD_W-1:0];
            else
               scr_w = pwdata[COORD_W-1:0];
         end
      end
      pending = draw_q.size();
   end

endmodule

FILE: bench/tb_ansi_console_escape_parser.sv
`timescale 1ns / 1ps
module tb_ansi_console_escape_parser;
   import acep_pkg::*;
   import acep_tb_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned HOLD_CYCLES    = 250;
   localparam int unsigned HOLD_AT_BEAT   = 60;
   localparam int unsigned QUIET_FIRST    = 120;
   localparam int unsigned QUIET_LAST     = 175;
   localparam int unsigned PHASE_BEATS    = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = 1'b0;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_op;
   logic [12:0] rsp_pos_x, rsp_pos_y, rsp_span;
   logic [7:0]  rsp_glyph, rsp_fg_color, rsp_bg_color;
   logic        rsp_underline, rsp_last;
   logic [4:0]  rsp_cursor_first, rsp_cursor_stop;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic        pready;

   int          fail_count;
   int          pending_draws;
   int unsigned beats_in = 0;
   int unsigned idle_cycles = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   ansi_console_escape_parser dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_byte_in(req_byte_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_op(rsp_op), .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_glyph(rsp_glyph), .rsp_fg_color(rsp_fg_color), .rsp_bg_color(rsp_bg_color),
      .rsp_underline(rsp_underline), .rsp_span(rsp_span),
      .rsp_cursor_first(rsp_cursor_first), .rsp_cursor_stop(rsp_cursor_stop),
      .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   acep_scoreboard draw_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_byte_in(req_byte_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_op(rsp_op), .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_glyph(rsp_glyph), .rsp_fg_color(rsp_fg_color), .rsp_bg_color(rsp_bg_color),
      .rsp_underline(rsp_underline), .rsp_span(rsp_span),
      .rsp_cursor_first(rsp_cursor_first), .rsp_cursor_stop(rsp_cursor_stop),
      .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending(pending_draws)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (req_valid && req_ready)
         beats_in++;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pwrite && pready))
         idle_cycles = 0;
      else
         idle_cycles++;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT)
         @(negedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic bit quiet_now();
      return beats_in >= QUIET_FIRST && beats_in < QUIET_LAST;
   endfunction

   // hold off the draw side once the sender is well under way, else drop ready at random outside the quiet window
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_now() || $urandom_range(0, 99) >= 17;
      end
   end

   task automatic send_beat(input logic cmd, input logic [7:0] b);
      while (!quiet_now() && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_byte_in <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_beat(1'b0, s[i]);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_draws != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [COORD_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({index, 2'b00});
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_screen(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
      write_csr(CSR_SCREEN_WIDTH, w);
      write_csr(CSR_SCREEN_HEIGHT, h);
   endtask

   function automatic int unsigned pick_number();
      case ($urandom_range(0, 19)) inside
         [0:9]:   return $urandom_range(0, 9);
         [10:15]: return $urandom_range(0, 99);
         [16:18]: return $urandom_range(0, 9999);
         default: return $urandom_range(60000, 999999);
      endcase
   endfunction

   function automatic int unsigned pick_sgr();
      case ($urandom_range(0, 9))
         0:       return SGR_RESET;
         1:       return SGR_BOLD;
         2:       return SGR_DIM;
         3:       return SGR_UNDERLINE;
         4:       return SGR_BLINK;
         5:       return SGR_INVERT;
         6:       return SGR_HIDE;
         7:       return SGR_FG_FIRST + $urandom_range(0, 8);
         8:       return SGR_BG_FIRST + $urandom_range(0, 8);
         default: return $urandom_range(0, 99);
      endcase
   endfunction

   function automatic logic [7:0] pick_final();
      case ($urandom_range(0, 16))
         0, 1:    return FIN_SGR;
         2:       return FIN_UP;
         3:       return FIN_DOWN;
         4:       return FIN_RIGHT;
         5:       return FIN_LEFT;
         6, 7:    return FIN_HOME;
         8:       return FIN_CLEAR;
         9:       return FIN_ERASE;
         10:      return FIN_SAVE;
         11:      return FIN_RESTORE;
         12:      return FIN_SHAPE_OFF;
         13:      return FIN_SHAPE_SET;
         14:      return BYTE_ESC;
         15:      return BYTE_NL;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_sequence();
      logic [7:0]  fin;
      int unsigned count;
      fin   = pick_final();
      count = $urandom_range(0, 3);
      send_beat(1'b0, BYTE_ESC);
      send_beat(1'b0, BYTE_LBRACKET);
      for (int i = 0; i < count; i++) begin
         if (i > 0)
            send_beat(1'b0, BYTE_SEMI);
         if ($urandom_range(0, 9) == 0)
            send_beat(1'b1, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 7) != 0) begin
            if (fin == FIN_SGR)
               send_text($sformatf("%0d", pick_sgr()));
            else if (fin == FIN_SHAPE_SET)
               send_text($sformatf("%0d", $urandom_range(0, 20)));
            else
               send_text($sformatf("%0d", pick_number()));
         end
      end
      send_beat(1'b0, fin);
   endtask

   task automatic run_random(input int unsigned beats);
      int unsigned goal;
      goal = beats_in + beats;
      while (beats_in < goal) begin
         case ($urandom_range(0, 19)) inside
            [0:5]:   send_beat(1'b0, 8'($urandom_range(0, 255)));
            [6:7]:   send_beat(1'b0, BYTE_NL);
            8:       send_beat(1'b1, 8'($urandom_range(0, 255)));
            [9:17]:  send_sequence();
            default: begin
               send_beat(1'b0, BYTE_ESC);
               if ($urandom_range(0, 2) == 0)
                  send_beat(1'b0, BYTE_ESC);
               send_beat(1'b0, 8'($urandom_range(0, 255)));
            end
         endcase
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      set_screen(WIDTH_RESET, HEIGHT_RESET);

      send_beat(1'b0, 8'h00);
      send_beat(1'b0, 8'hff);
      send_beat(1'b1, 8'h5a);
      send_text("\n\033x\033\033[70000B\n\033[J\033[K\033[Z");
      run_random(PHASE_BEATS);

      settle();
      set_screen(13'd8, 13'd16);
      run_random(PHASE_BEATS);

      settle();
      set_screen(13'd4096, 13'd4096);
      run_random(PHASE_BEATS);

      settle();
      set_screen(13'd80, 13'd48);
      run_random(PHASE_BEATS);

      settle();
      set_screen(13'd123, 13'd200);
      run_random(PHASE_BEATS);

      settle();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/acep_pkg.sv
design/acep_front.sv
design/acep_queue.sv
design/acep_back.sv
design/ansi_console_escape_parser.sv
design/acep_checker.sv
bench/acep_checker.sv
bench/tb_ansi_console_escape_parser.sv
